### hw/rtl/stb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg
// Shared constants and types for the swing trajectory Bezier core.
// ----------------------------------------------------------------------------
package stb_pkg;

   // fixed-point format of positions and of the blend weight
   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = 32;              // register and result width
   localparam int PT_W       = POS_W + 1;       // control points hold 33-bit differences
   localparam int WGT_W      = FRAC_BITS + 1;   // weight 0 .. 2^FRAC_BITS
   localparam int PHASE_W    = 17;
   localparam int NPTS       = 12;
   localparam int LVL_W      = 4;               // holds 1 .. NPTS-1
   localparam int CSR_IDX_W  = 3;

   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(65536);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIFT_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFT_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOUCH_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOUCH_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_HEIGHT = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   // control strobes from the sequencer
   typedef struct packed {
      logic ready;
      logic load;
      logic step;
      logic emit;
   } ctrl_type;

endpackage

`default_nettype wire

### hw/rtl/swing_trajectory_bezier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swing_trajectory_bezier_core
// Degree-11 Bezier foot swing path, evaluated by de Casteljau's scheme with one
// blend per lane, both sharing the weight, that serve the x and y lanes in the same cycle.
// ----------------------------------------------------------------------------
// Flow: control points load at the edge that accepts a req word, then the
//   66 blend steps run and a saturate/output step registers the result.
// The next word is taken only after the result has been emitted: the 66
//   dependent blends and the output step keep the sequencer busy.
//   A finished result waits in the output register while the next word runs.
// Reset: synchronous, active high; configuration registers clear to 0, the
//   sequencer idles and no result is pending.
// ----------------------------------------------------------------------------
module swing_trajectory_bezier_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream: [16:0] phase, [23:17] zero
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,
   // result stream: [31:0] foot_x, [63:32] foot_y
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,
   // configuration
   input  wire logic                           csr_we,
   input  wire logic [stb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [stb_pkg::POS_W-1:0]      csr_wdata
);

   localparam int PT_W  = stb_pkg::PT_W;
   localparam int WGT_W = stb_pkg::WGT_W;
   localparam int NPTS  = stb_pkg::NPTS;
   localparam int POS_W = stb_pkg::POS_W;
   localparam int LVL_W = stb_pkg::LVL_W;
   localparam int PROD_W = PT_W + WGT_W + 1;
   localparam int SUM_W  = PT_W + 1;

   // one blend a + floor(((b - a) * w + half) / 2^FRAC_BITS)
   function automatic logic signed [PT_W-1:0] blend(
      input logic signed [PT_W-1:0] a,
      input logic signed [PT_W-1:0] b,
      input logic        [WGT_W-1:0] w
   );
      logic signed [PT_W:0]     d;
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] sh;
      d    = (PT_W+1)'(b) - (PT_W+1)'(a);
      prod = d * $signed({1'b0, w});
      prod = prod + (PROD_W'(1) <<< (stb_pkg::FRAC_BITS - 1));
      sh   = prod >>> stb_pkg::FRAC_BITS;
      return a + PT_W'(sh);
   endfunction

   // saturate offset + curve point to 32 bits
   function automatic logic [POS_W-1:0] sat_add(
      input logic signed [POS_W-1:0] ofs,
      input logic signed [PT_W-1:0]  pt
   );
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(ofs) + SUM_W'(pt);
      if (s[SUM_W-1:POS_W-1] == '0 || s[SUM_W-1:POS_W-1] == '1) begin
         return s[POS_W-1:0];
      end else if (s[SUM_W-1]) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         return {1'b0, {(POS_W-1){1'b1}}};
      end
   endfunction

   // configuration registers
   logic signed [POS_W-1:0] lift_x_ff, lift_y_ff, touch_x_ff, touch_y_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_x_ff  <= '0;
         lift_y_ff  <= '0;
         touch_x_ff <= '0;
         touch_y_ff <= '0;
         height_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            stb_pkg::CSR_LIFT_X:      lift_x_ff  <= csr_wdata;
            stb_pkg::CSR_LIFT_Y:      lift_y_ff  <= csr_wdata;
            stb_pkg::CSR_TOUCH_X:     touch_x_ff <= csr_wdata;
            stb_pkg::CSR_TOUCH_Y:     touch_y_ff <= csr_wdata;
            stb_pkg::CSR_STEP_HEIGHT: height_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   stb_pkg::state_type state_ff, state_in;
   stb_pkg::ctrl_type  ctrl;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;    // current level: blends per pass
   logic [LVL_W-1:0]   idx_ff, idx_in;    // blend index within the level
   logic               last_step;
   logic               done_step;
   logic               out_free;

   assign last_step = (idx_ff == lvl_ff - LVL_W'(1));
   assign done_step = last_step && (lvl_ff == LVL_W'(1));
   assign out_free  = !rsp_tvalid || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stb_pkg::ST_IDLE: if (req_tvalid) state_in = stb_pkg::ST_RUN;
         stb_pkg::ST_RUN:  if (done_step)  state_in = stb_pkg::ST_HOLD;
         stb_pkg::ST_HOLD: if (out_free)   state_in = stb_pkg::ST_IDLE;
         default:          state_in = stb_pkg::ST_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         stb_pkg::ST_IDLE: begin
            ctrl.ready = 1'b1;
            ctrl.load  = req_tvalid;
         end
         stb_pkg::ST_RUN:  ctrl.step = 1'b1;
         stb_pkg::ST_HOLD: ctrl.emit = out_free;
         default: ;
      endcase
   end

   assign req_tready = ctrl.ready;

   // level and index counters
   always_comb begin
      lvl_in = lvl_ff;
      idx_in = idx_ff;
      if (ctrl.load) begin
         lvl_in = LVL_W'(NPTS - 1);
         idx_in = '0;
      end else if (ctrl.step) begin
         if (last_step) begin
            lvl_in = lvl_ff - LVL_W'(1);
            idx_in = '0;
         end else begin
            idx_in = idx_ff + LVL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stb_pkg::ST_IDLE;
         lvl_ff   <= LVL_W'(NPTS - 1);
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         idx_ff   <= idx_in;
      end
   end

   // weight from the clamped phase
   logic [stb_pkg::PHASE_W-1:0]                    phase_sat;
   logic [stb_pkg::PHASE_W+stb_pkg::FRAC_BITS-1:0] phase_scaled;
   logic [WGT_W-1:0]                               wgt_ff, wgt_in;

   always_comb begin
      phase_sat = req_tdata[stb_pkg::PHASE_W-1:0];
      if (phase_sat > stb_pkg::PHASE_ONE) phase_sat = stb_pkg::PHASE_ONE;
      phase_scaled = {phase_sat, {stb_pkg::FRAC_BITS{1'b0}}} >> 16;
      wgt_in = ctrl.load ? phase_scaled[WGT_W-1:0] : wgt_ff;
   end

   // control point lanes: a shift line, blend taps at positions 0 and 1
   logic signed [PT_W-1:0] px_ff [NPTS];
   logic signed [PT_W-1:0] py_ff [NPTS];
   logic signed [PT_W-1:0] px_in [NPTS];
   logic signed [PT_W-1:0] py_in [NPTS];
   logic signed [PT_W-1:0] len, dh, half, hgt;
   logic signed [PT_W-1:0] bx, by;

   assign len  = PT_W'(touch_x_ff) - PT_W'(lift_x_ff);
   assign dh   = PT_W'(touch_y_ff) - PT_W'(lift_y_ff);
   assign half = len >>> 1;
   assign hgt  = PT_W'(height_ff);

   // blend units, one per lane, sharing the weight
   assign bx = blend(px_ff[0], px_ff[1], wgt_ff);
   assign by = blend(py_ff[0], py_ff[1], wgt_ff);

   always_comb begin
      for (int k = 0; k < NPTS; k++) begin
         px_in[k] = px_ff[k];
         py_in[k] = py_ff[k];
         if (ctrl.load) begin
            px_in[k] = (k < 5) ? '0 : (k < 7) ? half : len;
            py_in[k] = (k < 2) ? '0 : (k < 10) ? hgt : dh;
         end else if (ctrl.step) begin
            if (last_step) begin
               // drop the level's final point and close up by two
               if (LVL_W'(k) == lvl_ff - LVL_W'(1)) begin
                  px_in[k] = bx;
                  py_in[k] = by;
               end else if (k < NPTS - 2) begin
                  px_in[k] = px_ff[k+2];
                  py_in[k] = py_ff[k+2];
               end
            end else begin
               if (LVL_W'(k) == lvl_ff) begin
                  px_in[k] = bx;
                  py_in[k] = by;
               end else if (k < NPTS - 1) begin
                  px_in[k] = px_ff[k+1];
                  py_in[k] = py_ff[k+1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      wgt_ff <= wgt_in;
      for (int k = 0; k < NPTS; k++) begin
         px_ff[k] <= px_in[k];
         py_ff[k] <= py_in[k];
      end
   end

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2*POS_W-1:0]   rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {sat_add(lift_y_ff, py_ff[0]), sat_add(lift_x_ff, px_ff[0])};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_idx_in_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == stb_pkg::ST_RUN |-> idx_ff < lvl_ff)
      else $error("blend index beyond level");

   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == stb_pkg::ST_RUN |-> lvl_ff >= LVL_W'(1) && lvl_ff <= LVL_W'(NPTS - 1))
      else $error("level count out of range");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == stb_pkg::ST_RUN && lvl_ff == LVL_W'(NPTS - 1))
      else $error("accepted word did not start a run");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !rsp_tvalid || rsp_tready)
      else $error("result overwritten before taken");

endmodule

`default_nettype wire
